[rtl/psds_pkg.sv]
// Shared types, constants and helpers for the partial sphere direction sampler.
package psds_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_STAGES_MAX = 24;
   localparam int SQRT_BITS         = 15;

   localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
   localparam logic signed [20:0] ONE_Q14  = 21'sd16384;

   localparam logic [1:0] CSR_PHI_MAX_TURNS = 2'd0;
   localparam logic [1:0] CSR_COS_THETA_MIN = 2'd1;
   localparam logic [1:0] CSR_COS_THETA_MAX = 2'd2;

   typedef struct packed {
      logic [15:0] u0;
      logic [15:0] u1;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsp_type;

   typedef struct packed {
      logic [16:0]        phi_max_turns;
      logic signed [15:0] cos_theta_min;
      logic signed [15:0] cos_theta_max;
   } cfg_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'd536870912;
         1: v = 32'd316933406;
         2: v = 32'd167458907;
         3: v = 32'd85004756;
         4: v = 32'd42667331;
         5: v = 32'd21354465;
         6: v = 32'd10679838;
         7: v = 32'd5340245;
         8: v = 32'd2670163;
         9: v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // saturate to plus or minus one in Q2.14
   function automatic logic signed [15:0] clamp_q14(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > ONE_Q14) begin
         r = 16'sd16384;
      end else if (v < -ONE_Q14) begin
         r = -16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[rtl/psds_front.sv]
// Front stages: polar scale multiply, z with saturation, radicand, azimuth angle.
module psds_front (
   input  logic               clock,
   input  logic               en,
   input  psds_pkg::cfg_type  cfg,
   input  psds_pkg::req_type  req,
   output logic [28:0]        w,
   output logic signed [15:0] z,
   output logic [31:0]        t
);

   logic signed [16:0] d;
   logic signed [33:0] p_in, p_ff;
   logic [32:0]        tfull;
   logic [31:0]        t1_ff, t2_ff, t3_ff;
   logic signed [34:0] pr;
   logic signed [18:0] q;
   logic signed [19:0] zr;
   logic signed [15:0] z_in, z2_ff, z3_ff;
   logic signed [31:0] zz;
   logic [28:0]        w_in, w_ff;

   always_comb begin
      d     = {cfg.cos_theta_min[15], cfg.cos_theta_min}
            - {cfg.cos_theta_max[15], cfg.cos_theta_max};
      p_in  = $signed({1'b0, req.u0}) * d;
      tfull = cfg.phi_max_turns * req.u1;
   end

   // round to nearest on the Q.30 product, then subtract from cos_theta_min
   always_comb begin
      pr   = {p_ff[33], p_ff} + 35'sd32768;
      q    = pr[34:16];
      zr   = {{4{cfg.cos_theta_min[15]}}, cfg.cos_theta_min} - {q[18], q};
      z_in = psds_pkg::clamp_q14({zr[19], zr});
   end

   always_comb begin
      zz = z2_ff * z2_ff;
      if (zz > 32'sd268435456) begin
         w_in = '0;
      end else begin
         w_in = 29'(32'sd268435456 - zz);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= p_in;
         t1_ff <= tfull[31:0];
         z2_ff <= z_in;
         t2_ff <= t1_ff;
         w_ff  <= w_in;
         z3_ff <= z2_ff;
         t3_ff <= t2_ff;
      end
   end

   assign w = w_ff;
   assign z = z3_ff;
   assign t = t3_ff;

endmodule

[rtl/psds_sqrt.sv]
// Pipelined digit-by-digit square root with round to nearest; carries z alongside.
module psds_sqrt #(
   parameter int PAD = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic [28:0]        w,
   input  logic signed [15:0] z_i,
   output logic [14:0]        r,
   output logic signed [15:0] z_o
);

   localparam int SB = psds_pkg::SQRT_BITS;

   logic [30:0]        rem_s  [0:SB];
   logic [14:0]        root_s [0:SB];
   logic signed [15:0] z_s    [0:SB];
   logic [30:0]        rem_ff [0:SB-1];
   logic [14:0]        root_ff[0:SB-1];
   logic signed [15:0] zq_ff  [0:SB-1];
   logic [14:0]        r_ff;
   logic signed [15:0] zr_ff;

   assign rem_s[0]  = {2'b00, w};
   assign root_s[0] = '0;
   assign z_s[0]    = z_i;

   for (genvar k = 0; k < SB; k++) begin : g_step
      localparam int Bit = SB - 1 - k;
      logic [30:0] test;
      logic        fits;

      always_comb begin
         test = (31'(root_s[k]) << (Bit + 1)) + (31'(1) << (2 * Bit));
         fits = rem_s[k] >= test;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? rem_s[k] - test : rem_s[k];
            root_ff[k] <= fits ? (root_s[k] | (15'(1) << Bit)) : root_s[k];
            zq_ff[k]   <= z_s[k];
         end
      end

      assign rem_s[k+1]  = rem_ff[k];
      assign root_s[k+1] = root_ff[k];
      assign z_s[k+1]    = zq_ff[k];
   end

   // round up when the remainder exceeds the root
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff  <= (rem_s[SB] > 31'(root_s[SB])) ? root_s[SB] + 15'd1 : root_s[SB];
         zr_ff <= z_s[SB];
      end
   end

   if (PAD > 0) begin : g_pad
      logic [14:0]        rp_ff[0:PAD-1];
      logic signed [15:0] zp_ff[0:PAD-1];
      always_ff @(posedge clock) begin
         if (en) begin
            rp_ff[0] <= r_ff;
            zp_ff[0] <= zr_ff;
            for (int i = 1; i < PAD; i++) begin
               rp_ff[i] <= rp_ff[i-1];
               zp_ff[i] <= zp_ff[i-1];
            end
         end
      end
      assign r   = rp_ff[PAD-1];
      assign z_o = zp_ff[PAD-1];
   end else begin : g_nopad
      assign r   = r_ff;
      assign z_o = zr_ff;
   end

endmodule

[rtl/psds_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module psds_cordic #(
   parameter int STAGES = psds_pkg::CORDIC_STAGES_DEF,
   parameter int PAD    = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        t,
   output logic signed [32:0] x,
   output logic signed [32:0] y,
   output logic [1:0]         quad
);

   logic signed [32:0] x_s[0:STAGES];
   logic signed [32:0] y_s[0:STAGES];
   logic signed [31:0] a_s[0:STAGES];
   logic [1:0]         q_s[0:STAGES];
   logic signed [32:0] x_ff[0:STAGES-1];
   logic signed [32:0] y_ff[0:STAGES-1];
   logic signed [31:0] a_ff[0:STAGES-1];
   logic [1:0]         q_ff[0:STAGES-1];

   assign x_s[0] = psds_pkg::GAIN_Q30;
   assign y_s[0] = '0;
   assign a_s[0] = {2'b00, t[29:0]};
   assign q_s[0] = t[31:30];

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [31:0] Atan = psds_pkg::atan_turns(i);
      logic signed [32:0] dx, dy;

      always_comb begin
         dx = x_s[i] >>> i;
         dy = y_s[i] >>> i;
      end

      // rotate towards zero residual angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (!a_s[i][31]) begin
               x_ff[i] <= x_s[i] - dy;
               y_ff[i] <= y_s[i] + dx;
               a_ff[i] <= a_s[i] - Atan;
            end else begin
               x_ff[i] <= x_s[i] + dy;
               y_ff[i] <= y_s[i] - dx;
               a_ff[i] <= a_s[i] + Atan;
            end
            q_ff[i] <= q_s[i];
         end
      end

      assign x_s[i+1] = x_ff[i];
      assign y_s[i+1] = y_ff[i];
      assign a_s[i+1] = a_ff[i];
      assign q_s[i+1] = q_ff[i];
   end

   if (PAD > 0) begin : g_pad
      logic signed [32:0] xp_ff[0:PAD-1];
      logic signed [32:0] yp_ff[0:PAD-1];
      logic [1:0]         qp_ff[0:PAD-1];
      always_ff @(posedge clock) begin
         if (en) begin
            xp_ff[0] <= x_s[STAGES];
            yp_ff[0] <= y_s[STAGES];
            qp_ff[0] <= q_s[STAGES];
            for (int i = 1; i < PAD; i++) begin
               xp_ff[i] <= xp_ff[i-1];
               yp_ff[i] <= yp_ff[i-1];
               qp_ff[i] <= qp_ff[i-1];
            end
         end
      end
      assign x    = xp_ff[PAD-1];
      assign y    = yp_ff[PAD-1];
      assign quad = qp_ff[PAD-1];
   end else begin : g_nopad
      assign x    = x_s[STAGES];
      assign y    = y_s[STAGES];
      assign quad = q_s[STAGES];
   end

endmodule

[rtl/psds_out.sv]
// Output stages: quadrant fold, radius scaling, rounding and saturation.
module psds_out (
   input  logic               clock,
   input  logic               en,
   input  logic [14:0]        r,
   input  logic signed [15:0] z,
   input  logic signed [32:0] x,
   input  logic signed [32:0] y,
   input  logic [1:0]         quad,
   output psds_pkg::rsp_type  rsp
);

   logic signed [33:0] c, s;
   logic signed [49:0] pc_ff, ps_ff;
   logic signed [15:0] z1_ff;
   logic signed [49:0] rc, rs;
   psds_pkg::rsp_type  rsp_in, rsp_ff;

   always_comb begin
      case (quad)
         2'd0: begin
            c = {x[32], x};
            s = {y[32], y};
         end
         2'd1: begin
            c = -{y[32], y};
            s = {x[32], x};
         end
         2'd2: begin
            c = -{x[32], x};
            s = -{y[32], y};
         end
         default: begin
            c = {y[32], y};
            s = -{x[32], x};
         end
      endcase
   end

   // floor shift by 30 keeps the sign of the rounded product
   always_comb begin
      rc = pc_ff + 50'sd536870912;
      rs = ps_ff + 50'sd536870912;
      rsp_in.dir_x = psds_pkg::clamp_q14({rc[49], rc[49:30]});
      rsp_in.dir_y = psds_pkg::clamp_q14({rs[49], rs[49:30]});
      rsp_in.dir_z = z1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff  <= $signed({1'b0, r}) * c;
         ps_ff  <= $signed({1'b0, r}) * s;
         z1_ff  <= z;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[rtl/partial_sphere_direction_sampler.sv]
// Partial sphere direction sampler: uniform (u0, u1) to a direction in Q2.14.
// Throughput: one beat per cycle unless the output stalls; the square root and CORDIC pipelines run side by side.
// A stalled result freezes the whole pipeline until the beat is taken.
// Reset clears valid bits and loads the configuration registers with a full sphere and full turn.
module partial_sphere_direction_sampler #(
   parameter int CORDIC_STAGES = psds_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psds_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [16:0]       csr_wdata
);

   localparam int SqrtDepth = psds_pkg::SQRT_BITS + 1;
   localparam int CoreDepth = (CORDIC_STAGES > SqrtDepth) ? CORDIC_STAGES : SqrtDepth;
   localparam int Latency   = 3 + CoreDepth + 2;

   psds_pkg::cfg_type  cfg_ff;
   logic [Latency-1:0] vld_ff;
   logic               advance;
   logic [28:0]        w;
   logic signed [15:0] z_f, z_r;
   logic [31:0]        t;
   logic [14:0]        r;
   logic signed [32:0] x, y;
   logic [1:0]         quad;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phi_max_turns <= 17'd65536;
         cfg_ff.cos_theta_min <= 16'sd16384;
         cfg_ff.cos_theta_max <= -16'sd16384;
      end else if (csr_wr_en) begin
         case (csr_index)
            psds_pkg::CSR_PHI_MAX_TURNS: cfg_ff.phi_max_turns <= csr_wdata;
            psds_pkg::CSR_COS_THETA_MIN: cfg_ff.cos_theta_min <= csr_wdata[15:0];
            psds_pkg::CSR_COS_THETA_MAX: cfg_ff.cos_theta_max <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // hold everything while the output beat waits
   assign advance   = !vld_ff[Latency-1] || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Latency-2:0], req_valid};
      end
   end

   psds_front u_front (
      .clock (clock),
      .en    (advance),
      .cfg   (cfg_ff),
      .req   (req_data),
      .w     (w),
      .z     (z_f),
      .t     (t)
   );

   psds_sqrt #(
      .PAD (CoreDepth - SqrtDepth)
   ) u_sqrt (
      .clock (clock),
      .en    (advance),
      .w     (w),
      .z_i   (z_f),
      .r     (r),
      .z_o   (z_r)
   );

   psds_cordic #(
      .STAGES (CORDIC_STAGES),
      .PAD    (CoreDepth - CORDIC_STAGES)
   ) u_cordic (
      .clock (clock),
      .en    (advance),
      .t     (t),
      .x     (x),
      .y     (y),
      .quad  (quad)
   );

   psds_out u_out (
      .clock (clock),
      .en    (advance),
      .r     (r),
      .z     (z_r),
      .x     (x),
      .y     (y),
      .quad  (quad),
      .rsp   (rsp_data)
   );

   assign rsp_valid = vld_ff[Latency-1];

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipeline moved while the output beat was stalled");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dir_x <= 16'sd16384 && rsp_data.dir_x >= -16'sd16384))
      else $error("dir_x beyond unit range");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dir_y <= 16'sd16384 && rsp_data.dir_y >= -16'sd16384))
      else $error("dir_y beyond unit range");

   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dir_z <= 16'sd16384 && rsp_data.dir_z >= -16'sd16384))
      else $error("dir_z beyond unit range");

endmodule
